// ===== src/nni_pkg.sv =====
// Package for the Newmark node integrator: constants, word types and the
// saturation helper. No dependencies.
package nni_pkg;

  localparam int NodeCount = 1024;
  localparam int FracBits  = 16;
  localparam int IdxW      = 10;
  localparam int AddrW     = 5;
  localparam int AccW      = 58;

  localparam logic [1:0] OpInit    = 2'd0;
  localparam logic [1:0] OpInfer   = 2'd1;
  localparam logic [1:0] OpAccept  = 2'd2;
  localparam logic [1:0] OpUnknown = 2'd3;

  localparam logic [2:0] RegStep  = 3'd0;
  localparam logic [2:0] RegInv   = 3'd1;
  localparam logic [2:0] RegKeep  = 3'd2;
  localparam logic [2:0] RegDispG = 3'd3;
  localparam logic [2:0] RegVelG  = 3'd4;
  localparam logic [2:0] RegGamma = 3'd5;

  typedef struct packed {
    logic signed [31:0] step_length;
    logic signed [31:0] inverse_step;
    logic signed [31:0] accel_keep_factor;
    logic signed [31:0] disp_accel_gain;
    logic signed [31:0] vel_accel_gain;
    logic signed [31:0] gamma_weight;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [IdxW-1:0]    node_index;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_z;
  } node_cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
  } node_state_t;

  typedef enum logic [2:0] {
    StIdle, StRead, StCalc, StWrite, StDone
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sd2147483647);
    lo = AccW'(-64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== src/nni_if.sv =====
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; the payload type is a parameter.
interface nni_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/nni_mac.sv =====
// Shared rounding multiply-accumulate unit of the integrator.
// Depends on nni_pkg for the accumulator width.
module nni_mac #(
  parameter int FracBits = nni_pkg::FracBits
) (
  input  logic                             clk_i,
  input  logic signed [31:0]               a_i,
  input  logic signed [31:0]               b_i,
  input  logic signed [nni_pkg::AccW-1:0]  acc_i,
  output logic signed [nni_pkg::AccW-1:0]  sum_o
);
  localparam int AccW = nni_pkg::AccW;

  logic signed [63:0] prod_q;
  logic signed [63:0] rnd;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign rnd   = (prod_q + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  assign sum_o = acc_i + rnd[AccW-1:0];
endmodule

// ===== src/newmark_node_integrator.sv =====
// Top level of the Newmark-beta node integrator: APB registers, node memories,
// sequencer and the shared multiply unit. Depends on nni_pkg, nni_if, nni_mac.
//
//  channel  | dir | payload
//  in_if    | in  | op, node_index, val_x/y/z
//  out_if   | out | pos, vel, acc on x, y, z
//  apb      | in  | six 32-bit coefficient registers
//
// Each axis passes through a read state, calculation steps and a write state, as every
// product uses the one multiplier: 12 steps for infer, 5 for accept and 1 for init.
// A word with an unknown op or node goes from the read state straight to done.
// Reset presets the coefficients and clears the sequencer; node memory needs no clearing.
// A finished word moves into the output register; the sequencer stalls only while
// that register still holds a word that has not been taken.
module newmark_node_integrator #(
  parameter int NodeCount = nni_pkg::NodeCount,
  parameter int FracBits  = nni_pkg::FracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  nni_if.sink                        in_if,
  nni_if.source                      out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nni_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  localparam int Entries = NodeCount * 3;
  localparam int MemW    = $clog2(Entries);
  localparam int AccW    = nni_pkg::AccW;

  nni_pkg::cfg_t cfg_q;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_length       <= 32'sd65536;
      cfg_q.inverse_step      <= 32'sd65536;
      cfg_q.accel_keep_factor <= 32'sd0;
      cfg_q.disp_accel_gain   <= 32'sd262144;
      cfg_q.vel_accel_gain    <= -32'sd262144;
      cfg_q.gamma_weight      <= 32'sd32768;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        nni_pkg::RegStep:  cfg_q.step_length       <= pwdata;
        nni_pkg::RegInv:   cfg_q.inverse_step      <= pwdata;
        nni_pkg::RegKeep:  cfg_q.accel_keep_factor <= pwdata;
        nni_pkg::RegDispG: cfg_q.disp_accel_gain   <= pwdata;
        nni_pkg::RegVelG:  cfg_q.vel_accel_gain    <= pwdata;
        nni_pkg::RegGamma: cfg_q.gamma_weight      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nni_pkg::RegStep:  prdata = cfg_q.step_length;
      nni_pkg::RegInv:   prdata = cfg_q.inverse_step;
      nni_pkg::RegKeep:  prdata = cfg_q.accel_keep_factor;
      nni_pkg::RegDispG: prdata = cfg_q.disp_accel_gain;
      nni_pkg::RegVelG:  prdata = cfg_q.vel_accel_gain;
      nni_pkg::RegGamma: prdata = cfg_q.gamma_weight;
      default:           prdata = '0;
    endcase
  end

  // Node state memories, one word per node and axis.
  logic [31:0] ref_mem [Entries];
  logic [31:0] dis_mem [Entries];
  logic [31:0] vel_mem [Entries];
  logic [31:0] acc_mem [Entries];
  logic [31:0] ten_mem [Entries];

  nni_pkg::state_e state_q, state_d;
  logic [1:0]  op_q;
  logic [nni_pkg::IdxW-1:0] node_q;
  logic signed [31:0] val_q [3];
  logic [1:0]  axis_q, axis_d;
  logic [3:0]  step_q, step_d;
  logic        bad_q;
  logic [MemW-1:0] addr;
  logic signed [31:0] rf_q, u_q, v_q, a_q, t_q;
  logic signed [31:0] an_q, vn_q, un_q, tmp_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [31:0] ma, mb;
  logic signed [AccW-1:0] macc, msum;
  logic signed [31:0] res_pos_q [3];
  logic signed [31:0] res_vel_q [3];
  logic signed [31:0] res_acc_q [3];
  nni_pkg::node_state_t out_q;
  logic        out_valid_q;
  logic signed [31:0] du, omg;

  assign addr = MemW'(32'(node_q) * 3 + 32'(axis_q));
  assign du   = val_q[axis_q];
  assign omg  = nni_pkg::sat32((AccW'(1) <<< FracBits) - AccW'(cfg_q.gamma_weight));

  nni_mac #(.FracBits(FracBits)) u_mac (
    .clk_i(clk_i), .a_i(ma), .b_i(mb), .acc_i(macc), .sum_o(msum)
  );

  // Operand select: a product issued in one step is accumulated in the next.
  always_comb begin
    ma = '0; mb = '0; macc = acc_q;
    if (op_q == nni_pkg::OpInfer) begin
      case (step_q)
        4'd0: begin ma = a_q;  mb = cfg_q.accel_keep_factor; end
        4'd2: begin ma = du;   mb = cfg_q.disp_accel_gain; end
        4'd4: begin ma = v_q;  mb = cfg_q.vel_accel_gain; end
        4'd6: begin ma = omg;  mb = a_q; end
        4'd8: begin ma = cfg_q.gamma_weight; mb = an_q; end
        4'd10: begin ma = cfg_q.step_length; mb = tmp_q; end
        default: ;
      endcase
    end else begin
      case (step_q)
        4'd1: begin ma = tmp_q; mb = cfg_q.inverse_step; end
        4'd3: begin ma = tmp_q; mb = cfg_q.inverse_step; end
        default: ;
      endcase
    end
  end

  logic [3:0] last_step;
  assign last_step = (op_q == nni_pkg::OpInfer) ? 4'd11 : 4'd4;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    case (state_q)
      nni_pkg::StIdle: if (in_if.valid) state_d = nni_pkg::StRead;
      nni_pkg::StRead: begin
        if (bad_q) state_d = nni_pkg::StDone;
        else begin
          state_d = nni_pkg::StCalc;
          step_d  = '0;
        end
      end
      nni_pkg::StCalc: begin
        if (op_q == nni_pkg::OpInit || step_q == last_step) state_d = nni_pkg::StWrite;
        else step_d = step_q + 4'd1;
      end
      nni_pkg::StWrite: begin
        if (axis_q == 2'd2) state_d = nni_pkg::StDone;
        else begin
          axis_d  = axis_q + 2'd1;
          state_d = nni_pkg::StRead;
        end
      end
      nni_pkg::StDone: if (!out_valid_q || out_if.ready) state_d = nni_pkg::StIdle;
      default: state_d = nni_pkg::StIdle;
    endcase
    if (state_q == nni_pkg::StIdle) axis_d = '0;
  end

  assign in_if.ready  = (state_q == nni_pkg::StIdle);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nni_pkg::StIdle;
      axis_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
      if (state_q == nni_pkg::StDone && state_d == nni_pkg::StIdle) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nni_pkg::StIdle && in_if.valid) begin
      op_q     <= in_if.data.op;
      node_q   <= in_if.data.node_index;
      val_q[0] <= in_if.data.val_x;
      val_q[1] <= in_if.data.val_y;
      val_q[2] <= in_if.data.val_z;
      bad_q    <= (32'(in_if.data.node_index) >= NodeCount) ||
                  (in_if.data.op == nni_pkg::OpUnknown);
      for (int i = 0; i < 3; i++) begin
        res_pos_q[i] <= '0;
        res_vel_q[i] <= '0;
        res_acc_q[i] <= '0;
      end
    end
    if (state_q == nni_pkg::StDone && state_d == nni_pkg::StIdle) begin
      out_q.pos_x <= res_pos_q[0]; out_q.pos_y <= res_pos_q[1]; out_q.pos_z <= res_pos_q[2];
      out_q.vel_x <= res_vel_q[0]; out_q.vel_y <= res_vel_q[1]; out_q.vel_z <= res_vel_q[2];
      out_q.acc_x <= res_acc_q[0]; out_q.acc_y <= res_acc_q[1]; out_q.acc_z <= res_acc_q[2];
    end
    if (state_q == nni_pkg::StRead) begin
      rf_q <= ref_mem[addr];
      u_q  <= dis_mem[addr];
      v_q  <= vel_mem[addr];
      a_q  <= acc_mem[addr];
      t_q  <= ten_mem[addr];
      acc_q <= '0;
    end
    if (state_q == nni_pkg::StCalc) begin
      if (op_q == nni_pkg::OpInfer) begin
        case (step_q)
          4'd0: un_q <= nni_pkg::sat32(AccW'(u_q) + AccW'(du));
          4'd1, 4'd3: acc_q <= msum;
          4'd5: begin
            an_q  <= nni_pkg::sat32(msum);
            acc_q <= '0;
          end
          4'd7: acc_q <= msum;
          4'd9: begin
            tmp_q <= nni_pkg::sat32(msum);
            acc_q <= AccW'(v_q);
          end
          4'd11: vn_q <= nni_pkg::sat32(msum);
          default: ;
        endcase
      end else if (op_q == nni_pkg::OpAccept) begin
        case (step_q)
          4'd0: tmp_q <= nni_pkg::sat32(AccW'(t_q) - AccW'(u_q));
          4'd2: begin
            vn_q  <= nni_pkg::sat32(msum);
            tmp_q <= nni_pkg::sat32(AccW'(nni_pkg::sat32(msum)) - AccW'(v_q));
          end
          4'd4: an_q <= nni_pkg::sat32(msum);
          default: ;
        endcase
      end
    end
    if (state_q == nni_pkg::StWrite) begin
      case (op_q)
        nni_pkg::OpInit: begin
          ref_mem[addr] <= du; dis_mem[addr] <= '0; vel_mem[addr] <= '0;
          acc_mem[addr] <= '0; ten_mem[addr] <= '0;
          res_pos_q[axis_q] <= du; res_vel_q[axis_q] <= '0; res_acc_q[axis_q] <= '0;
        end
        nni_pkg::OpInfer: begin
          ten_mem[addr] <= un_q;
          res_pos_q[axis_q] <= nni_pkg::sat32(AccW'(rf_q) + AccW'(un_q));
          res_vel_q[axis_q] <= vn_q; res_acc_q[axis_q] <= an_q;
        end
        default: begin
          vel_mem[addr] <= vn_q; acc_mem[addr] <= an_q; dis_mem[addr] <= t_q;
          res_pos_q[axis_q] <= nni_pkg::sat32(AccW'(rf_q) + AccW'(t_q));
          res_vel_q[axis_q] <= vn_q; res_acc_q[axis_q] <= an_q;
        end
      endcase
    end
  end
endmodule

// ===== sim/testbench.sv =====
// Testbench for newmark_node_integrator: directed and random init, infer, accept and
// unknown-op words checked against a built-in Newmark-beta predictor.
// Depends on nni_pkg, nni_if and the integrator RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [nni_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nni_if #(.T(nni_pkg::node_cmd_t))   cmd_ch ();
  nni_if #(.T(nni_pkg::node_state_t)) res_ch ();

  newmark_node_integrator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (cmd_ch),
    .out_if  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  int coef [6];
  int ref_pos [nni_pkg::NodeCount*3];
  int disp [nni_pkg::NodeCount*3];
  int vel [nni_pkg::NodeCount*3];
  int acc [nni_pkg::NodeCount*3];
  int tent [nni_pkg::NodeCount*3];
  bit node_live [nni_pkg::NodeCount];

  nni_pkg::node_state_t expected_states[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int config_writes = 0;
  int cycles = 0;

  function automatic longint rnd_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (nni_pkg::FracBits - 1));
    return p >>> nni_pkg::FracBits;
  endfunction

  function automatic int clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic nni_pkg::node_state_t integrate(nni_pkg::node_cmd_t c);
    nni_pkg::node_state_t r;
    int pos [3];
    int vn [3];
    int an [3];
    int val [3];
    int i;
    longint u, v, a, du, un;
    int omg, mix;
    r = '0;
    val[0] = c.val_x;
    val[1] = c.val_y;
    val[2] = c.val_z;
    if (c.op == nni_pkg::OpUnknown) return r;
    for (int k = 0; k < 3; k++) begin
      i = c.node_index * 3 + k;
      u = disp[i];
      v = vel[i];
      a = acc[i];
      if (c.op == nni_pkg::OpInit) begin
        ref_pos[i] = val[k];
        disp[i] = 0;
        vel[i] = 0;
        acc[i] = 0;
        tent[i] = 0;
        pos[k] = val[k];
        vn[k] = 0;
        an[k] = 0;
      end else if (c.op == nni_pkg::OpInfer) begin
        du = val[k];
        tent[i] = clamp(u + du);
        an[k] = clamp(rnd_mul(a, coef[nni_pkg::RegKeep]) + rnd_mul(du, coef[nni_pkg::RegDispG])
                      + rnd_mul(v, coef[nni_pkg::RegVelG]));
        omg = clamp((64'sd1 <<< nni_pkg::FracBits) - coef[nni_pkg::RegGamma]);
        mix = clamp(rnd_mul(omg, a) + rnd_mul(coef[nni_pkg::RegGamma], an[k]));
        vn[k] = clamp(v + rnd_mul(coef[nni_pkg::RegStep], mix));
        pos[k] = clamp(longint'(ref_pos[i]) + tent[i]);
      end else begin
        un = tent[i];
        vn[k] = clamp(rnd_mul(clamp(un - u), coef[nni_pkg::RegInv]));
        an[k] = clamp(rnd_mul(clamp(longint'(vn[k]) - v), coef[nni_pkg::RegInv]));
        vel[i] = vn[k];
        acc[i] = an[k];
        disp[i] = int'(un);
        pos[k] = clamp(longint'(ref_pos[i]) + un);
      end
    end
    r = {pos[0], pos[1], pos[2], vn[0], vn[1], vn[2], an[0], an[1], an[2]};
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** newmark_node_integrator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    nni_pkg::node_state_t want;
    logic [8:0][31:0] w_f;
    logic [8:0][31:0] g_f;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected word %h", $time, res_ch.data);
        errors++;
      end else begin
        want = expected_states.pop_front();
        w_f = want;
        g_f = res_ch.data;
        for (int f = 8; f >= 0; f--) begin
          if (w_f[f] !== g_f[f]) begin
            $display("%0t: field %0d expected %h actual %h", $time, 8 - f, w_f[f], g_f[f]);
            errors++;
          end
        end
        words_checked++;
      end
    end
  end

  task automatic send_word(nni_pkg::node_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk_i); while (!cmd_ch.ready);
    expected_states.push_back(integrate(c));
    words_sent++;
  endtask

  task automatic drain();
    @(posedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    coef[idx] = val;
    config_writes++;
  endtask

  task automatic load_coefs(int s, int inv, int keep, int dg, int vg, int g);
    write_reg(nni_pkg::RegStep, s);
    write_reg(nni_pkg::RegInv, inv);
    write_reg(nni_pkg::RegKeep, keep);
    write_reg(nni_pkg::RegDispG, dg);
    write_reg(nni_pkg::RegVelG, vg);
    write_reg(nni_pkg::RegGamma, g);
  endtask

  function automatic nni_pkg::node_cmd_t make_cmd(logic [1:0] op, int n, int x, int y, int z);
    nni_pkg::node_cmd_t c;
    c.op = op;
    c.node_index = n[nni_pkg::IdxW-1:0];
    c.val_x = x;
    c.val_y = y;
    c.val_z = z;
    if (op == nni_pkg::OpInit) node_live[n] = 1'b1;
    return c;
  endfunction

  function automatic int rand_val();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(2097151)) - 1048576;
    endcase
  endfunction

  task automatic test_directed();
    send_word(make_cmd(nni_pkg::OpInit, 0, 32'sh7fffffff, 32'sh80000000, 0));
    send_word(make_cmd(nni_pkg::OpAccept, 0, 1, 2, 3));
    send_word(make_cmd(nni_pkg::OpInfer, 0, 32'sh7fffffff, 32'sh80000000, -1));
    send_word(make_cmd(nni_pkg::OpInfer, 0, 32'sh80000000, 32'sh7fffffff, 1));
    send_word(make_cmd(nni_pkg::OpAccept, 0, 0, 0, 0));
    send_word(make_cmd(nni_pkg::OpInit, 1023, -65536, 65536, 32'h55555555));
    send_word(make_cmd(nni_pkg::OpInfer, 1023, 65536, -65536, 32768));
    send_word(make_cmd(nni_pkg::OpAccept, 1023, -1, -1, -1));
    send_word(make_cmd(nni_pkg::OpInfer, 1023, 32'hAAAAAAAA, 32'h55555555, 0));
    send_word(make_cmd(nni_pkg::OpAccept, 1023, 0, 0, 0));
    send_word(make_cmd(nni_pkg::OpUnknown, 1023, -1, -1, -1));
    send_word(make_cmd(nni_pkg::OpUnknown, 0, 0, 0, 0));
    send_word(make_cmd(nni_pkg::OpInit, 512, 0, 0, 0));
    send_word(make_cmd(nni_pkg::OpInfer, 512, 32'h7fff0000, 32'h7fff0000, 32'h80010000));
    send_word(make_cmd(nni_pkg::OpInfer, 512, 32'h7fff0000, 32'h7fff0000, 32'h80010000));
    send_word(make_cmd(nni_pkg::OpAccept, 512, 0, 0, 0));
    send_word(make_cmd(nni_pkg::OpAccept, 512, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    int n;
    int pick;
    logic [1:0] op;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      if (k < count / 8) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
      end
      pick = $urandom_range(31);
      n = (pick < 16) ? pick : 992 + pick;
      if ($urandom_range(19) == 0) n = $urandom_range(nni_pkg::NodeCount - 1);
      pick = $urandom_range(99);
      if (!node_live[n] || pick < 8) op = nni_pkg::OpInit;
      else if (pick < 12) op = nni_pkg::OpUnknown;
      else if (pick < 58) op = nni_pkg::OpInfer;
      else op = nni_pkg::OpAccept;
      send_word(make_cmd(op, n, rand_val(), rand_val(), rand_val()));
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_config_sweep();
    load_coefs(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh7fffffff);
    test_random(60, 0, 0);
    load_coefs(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh80000000);
    test_random(60, 30, 30);
    load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    test_random(60, 0, 50);
    load_coefs(32'sd6554, 32'sd655360, -32'sd65536, 32'sd2621440, -32'sd262144, 32'sd32768);
    test_random(60, 0, 0);
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    coef[nni_pkg::RegStep] = 65536;
    coef[nni_pkg::RegInv] = 65536;
    coef[nni_pkg::RegKeep] = 0;
    coef[nni_pkg::RegDispG] = 262144;
    coef[nni_pkg::RegVelG] = -262144;
    coef[nni_pkg::RegGamma] = 32768;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 82, 0);
    test_random(250, 0, 82);
    test_random(250, 32, 32);
    test_config_sweep();
    $display("Sent %0d words and checked %0d results over %0d register writes,",
             words_sent, words_checked, config_writes);
    $display("with idle and stall phases on both channels and extreme coefficients.");
    if (errors == 0 && expected_states.size() == 0) begin
      $display("** newmark_node_integrator: PASSED **");
    end else begin
      $display("** newmark_node_integrator: FAILED **");
    end
    $finish;
  end

endmodule
